/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocking and reset gating for the concurrent checks of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define CHK_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error(msg);

`endif

/* sv/ndd_pkg.sv */
// ----------------------------------------------------------------------------
// Divided-difference package
// Widths and the result bundle shared by the sequencer and the divider.
// ----------------------------------------------------------------------------
package ndd_pkg;

	localparam int unsigned COEF_W  = 32;  // Q16.16 word
	localparam int unsigned ORDER_W = 6;
	localparam int unsigned NUM_W   = 33;  // difference of two Q16.16 words
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned DVD_W   = NUM_W + FRAC_W;

	typedef struct packed {
		logic              done;
		logic              err;
		logic [COEF_W-1:0] quo;
	} ndd_div_res_t;

endpackage

/* sv/newton_divided_differences_unit.sv */
// ----------------------------------------------------------------------------
// Newton divided-difference unit
// Collects interpolation nodes, builds the divided-difference table in place
// and streams out the Newton coefficients gamma_0 .. gamma_{n-1}.
// ----------------------------------------------------------------------------
// Nodes arrive on the s_ channel, one (x, y) pair per transfer; s_tlast marks
// the last node of a set. Nodes past MAX_NODES are dropped. While nodes are
// being collected s_tready stays high. After the last node s_tready drops
// until the final coefficient is taken. Each table entry is fetched through
// S_RA, S_RB and S_RC and then divided on the shared serial divider, which
// sets the latency from the last node until the first coefficient is offered.
// Coefficients then leave on the m_ channel in order; each is read in S_EMRD,
// registered in S_EMW and held in S_EMH until it is taken, so the next one is
// not fetched before then. m_tlast marks gamma_{n-1} and
// m_tuser carries the error flag of the whole run on every transfer.
// A stall on m_tready simply holds the current coefficient. Reset clears the
// node count, the error flag and the sequencer; stored data is not cleared.
module newton_divided_differences_unit
	import ndd_pkg::*;
#(
	parameter int unsigned MAX_NODES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // node_x[31:0], node_y[63:32]
	input  logic        s_tlast,   // final_node
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // coefficient[31:0], order[37:32], zero pad
	output logic        m_tlast,   // final_coefficient
	output logic        m_tuser    // spacing_error
);

	localparam int unsigned AW = $clog2(MAX_NODES);
	localparam int unsigned CW = $clog2(MAX_NODES + 1);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_LD0  = 10'b00_0000_0010,
		S_LD0W = 10'b00_0000_0100,
		S_RA   = 10'b00_0000_1000,
		S_RB   = 10'b00_0001_0000,
		S_RC   = 10'b00_0010_0000,
		S_DIV  = 10'b00_0100_0000,
		S_EMRD = 10'b00_1000_0000,
		S_EMW  = 10'b01_0000_0000,
		S_EMH  = 10'b10_0000_0000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      j_q;
	logic [CW-1:0]      e_q;
	logic               err_q;
	logic [COEF_W-1:0]  dprev_q;
	logic [COEF_W-1:0]  dnext_q;
	logic [COEF_W-1:0]  xj_q;
	logic               m_tvalid_q;
	logic [COEF_W-1:0]  coef_q;
	logic [ORDER_W-1:0] order_q;
	logic               last_q;

	logic               in_xfer;
	logic               room;
	logic [CW-1:0]      jk;
	logic [CW-1:0]      jk1;
	logic [CW-1:0]      j1;

	logic               x_we;
	logic [AW-1:0]      x_raddr;
	logic [COEF_W-1:0]  x_rdata;
	logic               d_we;
	logic [AW-1:0]      d_waddr;
	logic [COEF_W-1:0]  d_wdata;
	logic [AW-1:0]      d_raddr;
	logic [COEF_W-1:0]  d_rdata;
	logic               g_we;
	logic [COEF_W-1:0]  g_rdata;

	logic               div_start;
	logic signed [NUM_W-1:0] div_num;
	logic signed [NUM_W-1:0] div_den;
	ndd_div_res_t       div_res;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign room     = cnt_q < CW'(MAX_NODES);
	assign jk       = j_q + k_q;
	assign jk1      = jk + 1'b1;
	assign j1       = j_q + 1'b1;

	// Table memories: x values, working differences and finished coefficients.
	assign x_we    = in_xfer && room;
	assign x_raddr = (state_q == S_RB) ? jk[AW-1:0] : j_q[AW-1:0];

	assign d_we    = x_we || ((state_q == S_DIV) && div_res.done);
	assign d_waddr = (state_q == S_IDLE) ? cnt_q[AW-1:0] : j_q[AW-1:0];
	assign d_wdata = (state_q == S_IDLE) ? s_tdata[63:32] : div_res.quo;
	assign d_raddr = (state_q == S_LD0) ? AW'(0) : j1[AW-1:0];

	assign g_we    = (state_q == S_LD0W);

	assign div_start = (state_q == S_RC);
	assign div_num   = NUM_W'(signed'(dnext_q)) - NUM_W'(signed'(dprev_q));
	assign div_den   = NUM_W'(signed'(x_rdata)) - NUM_W'(signed'(xj_q));

	ndd_ram #(.WIDTH(COEF_W), .DEPTH(MAX_NODES)) u_xram (
		.clk   (clk),
		.we    (x_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (s_tdata[31:0]),
		.raddr (x_raddr),
		.rdata (x_rdata)
	);

	ndd_ram #(.WIDTH(COEF_W), .DEPTH(MAX_NODES)) u_dram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	ndd_ram #(.WIDTH(COEF_W), .DEPTH(MAX_NODES)) u_gram (
		.clk   (clk),
		.we    (g_we),
		.waddr (AW'(k_q - 1'b1)),
		.wdata (d_rdata),
		.raddr (e_q[AW-1:0]),
		.rdata (g_rdata)
	);

	ndd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			n_q        <= '0;
			k_q        <= '0;
			j_q        <= '0;
			e_q        <= '0;
			err_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (s_tlast) begin
							n_q     <= room ? CW'(cnt_q + 1'b1) : cnt_q;
							k_q     <= CW'(1);
							state_q <= S_LD0;
						end
					end
				end
				S_LD0: begin
					state_q <= S_LD0W;
				end
				S_LD0W: begin
					// d[0] now holds gamma_{k-1}; it was copied out this cycle.
					if (k_q == n_q) begin
						e_q     <= '0;
						state_q <= S_EMRD;
					end else begin
						j_q     <= '0;
						state_q <= S_RA;
					end
				end
				S_RA: begin
					state_q <= S_RB;
				end
				S_RB: begin
					state_q <= S_RC;
				end
				S_RC: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_res.done) begin
						err_q <= err_q | div_res.err;
						j_q   <= j1;
						if (jk1 < n_q) begin
							state_q <= S_RA;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_LD0;
						end
					end
				end
				S_EMRD: begin
					state_q <= S_EMW;
				end
				S_EMW: begin
					m_tvalid_q <= 1'b1;
					state_q    <= S_EMH;
				end
				S_EMH: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (last_q) begin
							cnt_q   <= '0;
							err_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= S_EMRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LD0W) begin
			dprev_q <= d_rdata;
		end
		if (state_q == S_RB) begin
			dnext_q <= d_rdata;
			xj_q    <= x_rdata;
		end
		if ((state_q == S_DIV) && div_res.done) begin
			// The old d[j+1] is the lower operand of the next quotient.
			dprev_q <= dnext_q;
		end
		if (state_q == S_EMW) begin
			coef_q  <= g_rdata;
			order_q <= ORDER_W'(e_q);
			last_q  <= (CW'(e_q + 1'b1) == n_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, order_q, coef_q};
	assign m_tlast  = last_q;
	assign m_tuser  = err_q;

endmodule

/* sv/ndd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ndd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/ndd_div.sv */
// ----------------------------------------------------------------------------
// Saturating fixed-point divider
// Radix-2 restoring division of (num * 2^16) / den, one quotient bit a cycle,
// truncated toward zero and saturated to the signed Q16.16 range.
// ----------------------------------------------------------------------------
module ndd_div
	import ndd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [NUM_W-1:0] den,
	output ndd_div_res_t            res
);

	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic                busy_q;
	logic                fin_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;
	logic [NUM_W-1:0]    rem_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [NUM_W-1:0]    dvs_q;
	logic                done_q;
	logic                err_q;
	logic [COEF_W-1:0]   quo_q;

	logic [NUM_W-1:0]    num_abs;
	logic [NUM_W-1:0]    den_abs;
	logic [NUM_W:0]      trial;
	logic                fits;
	logic [DVD_W-1:0]    pos_lim;
	logic [DVD_W-1:0]    neg_lim;

	assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign den_abs = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
	assign trial   = {rem_q, dvd_q[DVD_W-1]};
	assign fits    = trial >= {1'b0, dvs_q};
	assign pos_lim = DVD_W'(32'h7FFF_FFFF);
	assign neg_lim = DVD_W'(33'h0_8000_0000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(DVD_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1] ^ den[NUM_W-1];
			rem_q <= '0;
			dvd_q <= {num_abs, FRAC_W'(0)};
			dvs_q <= den_abs;
			err_q <= (den == '0);
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? NUM_W'(trial - {1'b0, dvs_q}) : trial[NUM_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end else if (fin_q) begin
			if (neg_q) begin
				if (dvd_q > neg_lim) begin
					err_q <= 1'b1;
					quo_q <= 32'h8000_0000;
				end else begin
					quo_q <= -dvd_q[COEF_W-1:0];
				end
			end else if (dvd_q > pos_lim) begin
				err_q <= 1'b1;
				quo_q <= 32'h7FFF_FFFF;
			end else begin
				quo_q <= dvd_q[COEF_W-1:0];
			end
		end
	end

	assign res.done = done_q;
	assign res.err  = err_q;
	assign res.quo  = quo_q;

endmodule

/* sv/ndd_checker.sv */
// ----------------------------------------------------------------------------
// Divided-difference port checker
// Watches the stream ports of the unit and flags sequencing slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ndd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	`CHK_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stall")
	`CHK_ASSERT(a_side_hold, m_tvalid && !m_tready |=> $stable(m_tlast) && $stable(m_tuser), "stall")
	`CHK_NEVER(a_one_side, s_tready && m_tvalid, "input taken while a coefficient is offered")
	`CHK_ASSERT(a_busy_after_last, s_tvalid && s_tready && s_tlast |=> !s_tready, "busy")
	`CHK_ASSERT(a_idle_after_run, m_tvalid && m_tready && m_tlast |=> s_tready, "idle")

endmodule

bind newton_divided_differences_unit ndd_checker u_ndd_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Newton divided-difference unit testbench
// Streams sets of interpolation nodes into the unit, checks every coefficient
// transfer against a local model of the in-place divided-difference table or
// typed values for some directed sets. The run starts with a table of directed
// sets (extremes, zero spacing, saturation, single nodes). Random sets follow,
// some of them longer than the node store, under several idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import ndd_pkg::*;

	localparam int NODE_CAP = 32;

	typedef struct {
		logic [COEF_W-1:0]  coef;
		logic [ORDER_W-1:0] order;
		logic               last;
		logic               err;
	} coef_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        last;
		int          n_typed;   // 0: use the model, else number of typed coefficients
		logic [31:0] c0;
		logic [31:0] c1;
		logic        err;
	} node_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	coef_t       coef_q[$];
	logic [31:0] set_x[$];
	logic [31:0] set_y[$];
	int          fail_count;
	int          nodes_sent;
	int          sets_sent;
	int          coefs_seen;
	int          src_idle;
	int          sink_stall;
	node_row_t   dir_rows[16];

	newton_divided_differences_unit #(.MAX_NODES(NODE_CAP)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("%0t: timeout, %0d coefficients still expected", $realtime, coef_q.size());
		$display("Test completed with failures");
		$finish;
	end

	// Builds the table for the stored set in place and queues gamma_0 .. gamma_{n-1}.
	function automatic void predict_coefficients();
		longint tbl[NODE_CAP];
		longint xs[NODE_CAP];
		longint num;
		longint den;
		longint q;
		int     n;
		logic   err;
		coef_t  row[NODE_CAP];
		n = set_x.size();
		err = 1'b0;
		for (int i = 0; i < n; i++) begin
			xs[i]  = longint'(signed'(set_x[i]));
			tbl[i] = longint'(signed'(set_y[i]));
		end
		for (int k = 0; k < n; k++) begin
			for (int j = 0; k > 0 && j + k < n; j++) begin
				num = tbl[j+1] - tbl[j];
				den = xs[j+k] - xs[j];
				if (den == 0) begin
					err = 1'b1;
					q = 0;
				end else begin
					q = (num * 65536) / den;
					if (q > 64'sd2147483647) begin
						err = 1'b1;
						q = 64'sd2147483647;
					end else if (q < -64'sd2147483648) begin
						err = 1'b1;
						q = -64'sd2147483648;
					end
				end
				tbl[j] = q;
			end
			row[k].coef  = tbl[0][31:0];
			row[k].order = k[ORDER_W-1:0];
			row[k].last  = (k + 1 == n);
		end
		for (int k = 0; k < n; k++) begin
			row[k].err = err;
			coef_q.push_back(row[k]);
		end
	endfunction

	// Sends one node; with use_model set, the model runs once the final node of a
	// set is taken. s_tvalid stays high after the transfer so that the next node
	// can follow directly; the caller drops it after the last node of the run.
	task automatic send_node(input logic [31:0] x, input logic [31:0] y, input logic last,
	                         input bit use_model);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		nodes_sent++;
		if (set_x.size() < NODE_CAP) begin
			set_x.push_back(x);
			set_y.push_back(y);
		end
		if (last) begin
			if (use_model) predict_coefficients();
			set_x.delete();
			set_y.delete();
			sets_sent++;
		end
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(3))
			0: rand_word = $urandom();
			1: rand_word = $urandom_range(32'h0008_0000) - 32'h0004_0000;
			2: rand_word = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
			default: rand_word = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	task automatic send_random_set(input int n);
		logic [31:0] x;
		logic [31:0] base;
		base = $urandom();
		for (int i = 0; i < n; i++) begin
			// Mostly well-spaced abscissas; now and then a repeat or a wild value.
			case ($urandom_range(9))
				0: x = base;
				1: x = rand_word();
				default: x = base + (i + 1) * ($urandom_range(32'h0004_0000) + 1);
			endcase
			if ($urandom_range(9) != 0) base = x;
			send_node(x, rand_word(), i == n - 1, 1'b1);
		end
	endtask

	// Receiver side: random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall);
		end
	end

	always @(posedge clk) begin
		coef_t want;
		if (arst_n && m_tvalid && m_tready) begin
			coefs_seen++;
			if (coef_q.size() == 0) begin
				$display("%0t: unexpected coefficient transfer coef=%h order=%0d last=%b err=%b",
				         $realtime, m_tdata[31:0], m_tdata[37:32], m_tlast, m_tuser);
				fail_count++;
			end else begin
				want = coef_q.pop_front();
				if (m_tdata[31:0] !== want.coef || m_tdata[37:32] !== want.order ||
				    m_tdata[39:38] !== 2'b00 || m_tlast !== want.last ||
				    m_tuser !== want.err) begin
					$display("%0t: mismatch expected coef=%h order=%0d last=%b err=%b",
					         $realtime, want.coef, want.order, want.last, want.err);
					$display("%0t:          actual   coef=%h order=%0d last=%b err=%b pad=%b",
					         $realtime, m_tdata[31:0], m_tdata[37:32], m_tlast, m_tuser,
					         m_tdata[39:38]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		coef_t typed;
		int    wait_cycles;
		int    set_len;
		fail_count = 0;
		nodes_sent = 0;
		sets_sent  = 0;
		coefs_seen = 0;
		src_idle   = 0;
		sink_stall = 0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;

		// Single nodes at the extremes, a zero spacing, and saturation both ways.
		dir_rows[0]  = '{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1, 32'h7FFF_FFFF, 32'h0, 1'b0};
		dir_rows[1]  = '{32'h8000_0000, 32'h8000_0000, 1'b1, 1, 32'h8000_0000, 32'h0, 1'b0};
		dir_rows[2]  = '{32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1, 32'h0000_0000, 32'h0, 1'b0};
		dir_rows[3]  = '{32'h0001_0000, 32'h0000_0001, 1'b0, 0, 32'h0, 32'h0, 1'b0};
		dir_rows[4]  = '{32'h0001_0000, 32'h0000_0009, 1'b1, 2, 32'h0000_0001, 32'h0, 1'b1};
		dir_rows[5]  = '{32'h0000_0000, 32'h8000_0000, 1'b0, 0, 32'h0, 32'h0, 1'b0};
		dir_rows[6]  = '{32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 2, 32'h8000_0000, 32'h7FFF_FFFF,
		                 1'b1};
		dir_rows[7]  = '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 0, 32'h0, 32'h0, 1'b0};
		dir_rows[8]  = '{32'h0000_0001, 32'h8000_0000, 1'b1, 2, 32'h7FFF_FFFF, 32'h8000_0000,
		                 1'b1};
		// Cubic on x = 0..3, then a set spanning the whole abscissa range.
		dir_rows[9]  = '{32'h0000_0000, 32'h0000_0000, 1'b0, 0, 32'h0, 32'h0, 1'b0};
		dir_rows[10] = '{32'h0001_0000, 32'h0001_0000, 1'b0, 0, 32'h0, 32'h0, 1'b0};
		dir_rows[11] = '{32'h0002_0000, 32'h0008_0000, 1'b0, 0, 32'h0, 32'h0, 1'b0};
		dir_rows[12] = '{32'h0003_0000, 32'h001B_0000, 1'b1, 0, 32'h0, 32'h0, 1'b0};
		dir_rows[13] = '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, 32'h0, 32'h0, 1'b0};
		dir_rows[14] = '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0, 32'h0, 32'h0, 1'b0};
		dir_rows[15] = '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 0, 32'h0, 32'h0, 1'b0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_node(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last, dir_rows[i].n_typed == 0);
			for (int k = 0; k < dir_rows[i].n_typed; k++) begin
				typed.coef  = (k == 0) ? dir_rows[i].c0 : dir_rows[i].c1;
				typed.order = k[ORDER_W-1:0];
				typed.last  = (k + 1 == dir_rows[i].n_typed);
				typed.err   = dir_rows[i].err;
				coef_q.push_back(typed);
			end
		end

		// Random sets over five idling phases; a few sets overflow the node store.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin src_idle = 60; sink_stall = 0;  end
				2: begin src_idle = 0;  sink_stall = 60; end
				3: begin src_idle = 32; sink_stall = 32; end
				default: begin src_idle = 0; sink_stall = 0; end
			endcase
			for (int s = 0; s < 16; s++) begin
				if (s == 8 && ph != 4)
					set_len = NODE_CAP + $urandom_range(4) - 1;
				else if ($urandom_range(7) == 0)
					set_len = $urandom_range(16, 7);
				else
					set_len = $urandom_range(5, 1);
				send_random_set(set_len);
			end
		end
		s_tvalid <= 1'b0;

		wait_cycles = 0;
		while (coef_q.size() != 0 && wait_cycles < 200_000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);

		$display("Sent %0d nodes in %0d sets, checked %0d coefficient transfers.",
		         nodes_sent, sets_sent, coefs_seen);
		if (fail_count == 0 && coef_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d coefficients never arrived", fail_count, coef_q.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/ndd_pkg.sv
sv/ndd_ram.sv
sv/ndd_div.sv
sv/newton_divided_differences_unit.sv
sv/ndd_checker.sv
tb/tb_top.sv
